[hdl/stx_frm_pkg.sv]
// Shared types and constants of the length-framed LRC receiver.
package stx_frm_pkg;

   // Framing bytes.
   localparam logic [7:0] STX_CODE = 8'h02;
   localparam logic [7:0] ETX_CODE = 8'h03;

   // Byte positions inside a frame, counting the start byte as one.
   localparam logic [15:0] CNT_STX    = 16'd1;
   localparam logic [15:0] CNT_LEN_HI = 16'd2;
   localparam logic [15:0] CNT_LEN_LO = 16'd3;

   // Start byte, two length bytes and the closing byte.
   localparam logic [16:0] HDR_TRL_LEN = 17'd4;

   // Reset value of the frame length limit.
   localparam logic [15:0] MAX_FRAME_LEN_RESET = 16'd1024;

   // Register map: register index 0 is the frame length limit.
   localparam logic REG_MAX_FRAME_LEN = 1'b0;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_OK       = 2'd1,
      KIND_BAD      = 2'd2,
      KIND_TOO_LONG = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [15:0] frame_len;
      logic        frame_end;
   } result_type;

endpackage

[hdl/stx_frm_if.sv]
// Valid/ready channel interfaces for received bytes and for results.
interface stx_frm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface stx_frm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  data_byte;
   logic [15:0] frame_len;
   logic        frame_end;

   modport source (output valid, output kind, output data_byte, output frame_len,
                   output frame_end, input ready);
   modport sink   (input valid, input kind, input data_byte, input frame_len,
                   input frame_end, output ready);
endinterface

[hdl/stx_frm_front.sv]
// Front end: accepts received bytes, tracks the frame and builds result records.
module stx_frm_front (
   input  logic                   clock,
   input  logic                   reset,
   stx_frm_req_if.sink            req,
   input  logic [15:0]            max_frame_len,
   input  logic                   q_full,
   output logic                   q_push,
   output stx_frm_pkg::result_type q_data
);

   logic        in_frame_ff, in_frame_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  lrc_ff, lrc_in;
   logic [7:0]  prev_ff, prev_in;

   logic        accept;
   logic [15:0] eff_count, eff_len, cnt_next;
   logic [7:0]  eff_lrc, eff_prev, lrc_next;
   logic [16:0] close_len;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      // A start byte seen while hunting begins from a cleared frame state.
      eff_count = in_frame_ff ? count_ff : '0;
      eff_len   = in_frame_ff ? len_ff   : '0;
      eff_lrc   = in_frame_ff ? lrc_ff   : '0;
      eff_prev  = in_frame_ff ? prev_ff  : '0;
      cnt_next  = eff_count + 16'd1;
      lrc_next  = eff_lrc ^ req.rx_byte;
      close_len = {1'b0, eff_len} + stx_frm_pkg::HDR_TRL_LEN;

      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      len_in      = len_ff;
      lrc_in      = lrc_ff;
      prev_in     = prev_ff;

      q_push           = 1'b0;
      q_data.kind      = stx_frm_pkg::KIND_PAYLOAD;
      q_data.data_byte = '0;
      q_data.frame_len = eff_len;
      q_data.frame_end = 1'b0;

      if (accept && (in_frame_ff || req.rx_byte == stx_frm_pkg::STX_CODE)) begin
         if (eff_count >= max_frame_len) begin
            // The limit is checked before counting, so the count never wraps.
            q_push           = 1'b1;
            q_data.kind      = stx_frm_pkg::KIND_TOO_LONG;
            q_data.frame_end = 1'b1;
            in_frame_in      = 1'b0;
            len_in           = eff_len;
         end else begin
            in_frame_in = 1'b1;
            count_in    = cnt_next;
            len_in      = eff_len;
            lrc_in      = lrc_next;
            prev_in     = req.rx_byte;
            priority if (cnt_next == stx_frm_pkg::CNT_STX) begin
               lrc_in  = '0;
               prev_in = '0;
            end else if (cnt_next == stx_frm_pkg::CNT_LEN_HI) begin
               len_in = {req.rx_byte, 8'h00};
            end else if (cnt_next == stx_frm_pkg::CNT_LEN_LO) begin
               len_in = {eff_len[15:8], req.rx_byte};
            end else if ({1'b0, cnt_next} == close_len) begin
               q_push           = 1'b1;
               q_data.kind      = (eff_prev == stx_frm_pkg::ETX_CODE && lrc_next == 8'h00)
                                  ? stx_frm_pkg::KIND_OK : stx_frm_pkg::KIND_BAD;
               q_data.frame_end = 1'b1;
               in_frame_in      = 1'b0;
            end else begin
               q_push           = 1'b1;
               q_data.data_byte = req.rx_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         len_ff      <= '0;
         lrc_ff      <= '0;
         prev_ff     <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         len_ff      <= len_in;
         lrc_ff      <= lrc_in;
         prev_ff     <= prev_in;
      end
   end

`ifndef SYNTH
   // Inside a frame the start byte has always been counted.
   a_count_in_frame: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> count_ff != 16'd0)
      else $error("frame open with zero byte count");

   // Only payload records carry a data byte, and only status records close a frame.
   a_record_shape: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_data.frame_end == (q_data.kind != stx_frm_pkg::KIND_PAYLOAD)) &&
                 (q_data.kind == stx_frm_pkg::KIND_PAYLOAD || q_data.data_byte == 8'h00))
      else $error("malformed result record");

   // A status record always returns the front end to hunting.
   a_status_hunts: assert property (@(posedge clock) disable iff (reset)
      q_push && q_data.frame_end |=> !in_frame_ff)
      else $error("frame still open after status");
`endif

endmodule

[hdl/stx_frm_fifo.sv]
// Short first-in first-out queue of result records between front and back end.
module stx_frm_fifo #(
   parameter int Depth = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  stx_frm_pkg::result_type push_data,
   output logic                    full,
   input  logic                    pop,
   output stx_frm_pkg::result_type pop_data,
   output logic                    empty
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

   stx_frm_pkg::result_type mem_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == FullCnt);
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   // Writers and readers must respect the queue's fill state.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from an empty queue");
`endif

endmodule

[hdl/stx_frm_back.sv]
// Back end: drains the queue into the registered result channel.
module stx_frm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  stx_frm_pkg::result_type q_data,
   output logic                    q_pop,
   stx_frm_rsp_if.source           rsp
);

   logic                    valid_ff, valid_in;
   stx_frm_pkg::result_type out_ff;

   // The output register reloads from a non-empty queue when empty or taken.
   assign q_pop    = !q_empty && (!valid_ff || rsp.ready);
   assign valid_in = q_pop || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_ff <= q_data;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.kind      = out_ff.kind;
   assign rsp.data_byte = out_ff.data_byte;
   assign rsp.frame_len = out_ff.frame_len;
   assign rsp.frame_end = out_ff.frame_end;

endmodule

[hdl/stx_length_lrc_frame_receiver.sv]
// Top level of the length-framed serial receiver with LRC check.
// A result passes the result queue and then the output register before it is offered.
// Throughput: one byte per cycle while the result queue is not full.
// A full result queue (depth QueueDepth) is the only thing that holds off new bytes.
// Reset is synchronous and active high: the receiver hunts for a start byte, the queue and
// the output register are emptied, and the frame length limit returns to 1024.
module stx_length_lrc_frame_receiver #(
   parameter int QueueDepth = 2
) (
   input  logic          clock,
   input  logic          reset,
   stx_frm_req_if.sink   req_chan,
   stx_frm_rsp_if.source rsp_chan,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [2:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready
);

   // The frame length limit. A write transaction on the register port writes it in the
   // access cycle; address bit 2 selects the register and the low bits are ignored.
   logic [15:0] max_len_ff, max_len_in;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      max_len_in = max_len_ff;
      if (csr_write && paddr[2] == stx_frm_pkg::REG_MAX_FRAME_LEN) begin
         max_len_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= stx_frm_pkg::MAX_FRAME_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   assign prdata = (paddr[2] == stx_frm_pkg::REG_MAX_FRAME_LEN) ? {16'h0000, max_len_ff}
                                                               : 32'h0000_0000;

   // The front end classifies every accepted byte and writes at most one result
   // record per transaction into the queue. The back end drains the queue into the
   // output register, so a stalled response channel only stops the input once the
   // queue has filled.
   logic                    q_push, q_full, q_pop, q_empty;
   stx_frm_pkg::result_type q_wr_data, q_rd_data;

   stx_frm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req           (req_chan),
      .max_frame_len (max_len_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_wr_data)
   );

   stx_frm_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty)
   );

   stx_frm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (q_rd_data),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the length-framed serial receiver with LRC check.
module tb_top;

   // Run length and pacing.
   localparam int RANDOM_ITEMS    = 1700;
   localparam int RSP_HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES    = 8;
   localparam int CYCLE_LIMIT     = 500000;

   typedef logic [7:0] byte_q_type [$];

   // How a generated frame is damaged, if at all.
   typedef enum {FRM_GOOD, FRM_BAD_ETX, FRM_BAD_LRC} frame_flaw_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   stx_frm_req_if req_bus ();
   stx_frm_rsp_if rsp_bus ();

   stx_length_lrc_frame_receiver u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #10 clock = ~clock;

   // Idling switches for both sides. The test process is their only writer.
   bit req_idle_en;
   bit rsp_idle_en;

   // The test bumps this count to ask the result ready driver for one long hold-off.
   int hold_asked;

   // Results still owed by the receiver, oldest first.
   stx_frm_pkg::result_type expected_results [$];

   int mismatch_count;
   int results_checked;
   int kind_seen [4];
   int bytes_sent;
   int frames_opened;
   int limit_count;
   int unsigned cycle_count;

   // Mirror of the frame length limit and of the frame tracking state.
   logic [15:0] frame_limit;
   bit          framing;
   logic [15:0] pos;
   logic [15:0] len_decl;
   logic [7:0]  xor_run;
   logic [7:0]  last_byte;

   function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
   endfunction

   // Drop back to hunting for a start byte. The declared length is kept, as a
   // later too-long status on a fresh frame only sees it after the new STX clears it.
   function automatic void frame_hunt();
      framing   = 1'b0;
      pos       = '0;
      xor_run   = '0;
      last_byte = '0;
   endfunction

   // Works out what one accepted byte produces. Returns 1 when it yields a result.
   function automatic bit predict_frame_byte(input logic [7:0] b,
                                             output stx_frm_pkg::result_type r);
      r = '0;
      if (!framing) begin
         if (b != stx_frm_pkg::STX_CODE)
            return 1'b0;
         framing   = 1'b1;
         pos       = '0;
         len_decl  = '0;
         xor_run   = '0;
         last_byte = '0;
         frames_opened++;
      end
      // The limit is tested before the byte is counted, so a zero limit
      // rejects the start byte itself and the position never wraps.
      if (pos >= frame_limit) begin
         r.kind      = stx_frm_pkg::KIND_TOO_LONG;
         r.frame_len = len_decl;
         r.frame_end = 1'b1;
         frame_hunt();
         return 1'b1;
      end
      pos = pos + 16'd1;
      if (pos == stx_frm_pkg::CNT_STX)
         return 1'b0;
      xor_run = xor_run ^ b;
      if (pos == stx_frm_pkg::CNT_LEN_HI) begin
         len_decl  = {b, 8'h00};
         last_byte = b;
         return 1'b0;
      end
      if (pos == stx_frm_pkg::CNT_LEN_LO) begin
         len_decl[7:0] = b;
         last_byte     = b;
         return 1'b0;
      end
      // Closing byte: the running XOR now includes it, so a good frame leaves zero.
      // For a zero length frame the byte before it is the low length byte.
      if ({1'b0, pos} == {1'b0, len_decl} + stx_frm_pkg::HDR_TRL_LEN) begin
         if (last_byte == stx_frm_pkg::ETX_CODE && xor_run == 8'h00)
            r.kind = stx_frm_pkg::KIND_OK;
         else
            r.kind = stx_frm_pkg::KIND_BAD;
         r.frame_len = len_decl;
         r.frame_end = 1'b1;
         frame_hunt();
         return 1'b1;
      end
      last_byte   = b;
      r.kind      = stx_frm_pkg::KIND_PAYLOAD;
      r.data_byte = b;
      r.frame_len = len_decl;
      return 1'b1;
   endfunction

   // Random byte with extra weight on the two framing codes.
   function automatic logic [7:0] rand_data();
      case ($urandom_range(7))
         0: return stx_frm_pkg::STX_CODE;
         1: return stx_frm_pkg::ETX_CODE;
         default: return 8'($urandom);
      endcase
   endfunction

   // Builds a frame of declared length len: STX, length, data, ETX if len > 0, LRC.
   function automatic byte_q_type make_frame(input logic [15:0] len,
                                             input frame_flaw_type flaw);
      byte_q_type f;
      logic [7:0] x;
      logic [7:0] b;
      f = {stx_frm_pkg::STX_CODE, len[15:8], len[7:0]};
      x = len[15:8] ^ len[7:0];
      for (int i = 1; i < int'(len); i++) begin
         b = rand_data();
         f.push_back(b);
         x = x ^ b;
      end
      if (len != 16'd0) begin
         b = stx_frm_pkg::ETX_CODE;
         if (flaw == FRM_BAD_ETX) begin
            do b = 8'($urandom); while (b == stx_frm_pkg::ETX_CODE);
         end
         f.push_back(b);
         x = x ^ b;
      end
      if (flaw == FRM_BAD_LRC)
         x = x ^ 8'($urandom_range(1, 255));
      f.push_back(x);
      return f;
   endfunction

   // Offers one byte until it is taken, with random gaps before it. The valid
   // stays high after the transaction so back-to-back bytes need no extra step.
   task automatic send_byte(input logic [7:0] b);
      stx_frm_pkg::result_type r;
      while (req_idle_en && $urandom_range(99) < 20) begin
         req_bus.valid   <= 1'b0;
         req_bus.rx_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
      if (predict_frame_byte(b, r))
         expected_results.push_back(r);
   endtask

   task automatic send_bytes(input byte_q_type q);
      foreach (q[i])
         send_byte(q[i]);
   endtask

   // Stops offering bytes and waits until every owed result has come back. The
   // extra cycles cover bytes that are still in the pipe but yield no result.
   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the frame length limit over the register port and reads it back.
   task automatic csr_write(input logic [15:0] value);
      paddr   <= {stx_frm_pkg::REG_MAX_FRAME_LEN, 2'b00};
      pwdata  <= {16'h0000, value};
      pwrite  <= 1'b1;
      psel    <= 1'b1;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      frame_limit = value;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {16'h0000, value})
         note_mismatch("frame length limit readback", {16'h0000, value}, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Hunting noise at both byte extremes, then a one byte frame, a zero length
   // frame, a frame carrying a start byte as data, and one with a broken LRC.
   task automatic test_framing_basics();
      send_bytes({8'hFF, 8'h00, 8'h55});
      send_bytes({stx_frm_pkg::STX_CODE, 8'h00, 8'h01, stx_frm_pkg::ETX_CODE, 8'h02});
      send_bytes({stx_frm_pkg::STX_CODE, 8'h00, 8'h00, 8'h00});
      send_bytes({stx_frm_pkg::STX_CODE, 8'h00, 8'h03, stx_frm_pkg::STX_CODE, 8'hFF,
                  stx_frm_pkg::ETX_CODE, 8'hFD});
      send_bytes({stx_frm_pkg::STX_CODE, 8'h00, 8'h02, 8'hFF, stx_frm_pkg::ETX_CODE,
                  8'h00});
      wait_drain();
   endtask

   // A zero limit rejects the start byte, a limit of two cuts the frame inside
   // its length, and a huge declared length can only end as too long.
   task automatic test_limit_edges();
      csr_write(16'd0);
      send_bytes({stx_frm_pkg::STX_CODE, 8'hAA});
      wait_drain();
      csr_write(16'd2);
      send_bytes({stx_frm_pkg::STX_CODE, 8'hAB, 8'hCD});
      wait_drain();
      csr_write(16'd6);
      send_bytes({stx_frm_pkg::STX_CODE, 8'hFF, 8'hFF, 8'h11, 8'h22, 8'h33, 8'h44});
      wait_drain();
      csr_write(stx_frm_pkg::MAX_FRAME_LEN_RESET);
      wait_drain();
   endtask

   // The result side holds off for a long stretch while the sender keeps
   // offering, so the result queue fills and input stalls. Then the sender
   // pauses until everything has drained before one more frame.
   task automatic test_backpressure();
      req_idle_en = 1'b0;
      hold_asked++;
      send_bytes(make_frame(16'd60, FRM_GOOD));
      wait_drain();
      send_bytes(make_frame(16'd20, FRM_BAD_LRC));
      wait_drain();
      req_idle_en = 1'b1;
   endtask

   // Mostly well-formed frames with random content under several limits, the
   // register maximum among them, mixed with cut frames, noise and frames that
   // run past the limit. The second setting runs with no idling on either side.
   task automatic test_random_traffic();
      logic [15:0]    limit_set [5];
      int             frame_bytes;
      int             pick;
      int             len;
      int             cut;
      frame_flaw_type flaw;
      byte_q_type     f;
      limit_set = '{16'd1024, 16'd65535, 16'd16, 16'd1, 16'd300};
      foreach (limit_set[p]) begin
         wait_drain();
         csr_write(limit_set[p]);
         limit_count++;
         req_idle_en = (p != 1);
         rsp_idle_en = (p != 1);
         frame_bytes = 0;
         while (frame_bytes < RANDOM_ITEMS / 5) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               if ($urandom_range(19) == 0)
                  len = $urandom_range(25, 200);
               else
                  len = $urandom_range(0, 24);
               if (pick < 56)
                  flaw = FRM_GOOD;
               else if (pick < 63)
                  flaw = FRM_BAD_ETX;
               else
                  flaw = FRM_BAD_LRC;
               f = make_frame(16'(len), flaw);
               send_bytes(f);
               frame_bytes += f.size();
            end else if (pick < 80) begin
               // A frame cut short: what follows is swallowed as its data.
               f   = make_frame(16'($urandom_range(1, 40)), FRM_GOOD);
               cut = $urandom_range(1, f.size() - 1);
               for (int i = 0; i < cut; i++)
                  send_byte(f[i]);
               frame_bytes += cut;
            end else if (pick < 90) begin
               repeat ($urandom_range(1, 4)) send_byte(rand_data());
            end else if (limit_set[p] <= 16'd300) begin
               // Declared length at or past the limit; send one byte beyond it.
               len = $urandom_range(int'(limit_set[p]), 65535);
               f   = {stx_frm_pkg::STX_CODE, 8'(len >> 8), 8'(len)};
               while (f.size() <= int'(limit_set[p]))
                  f.push_back(rand_data());
               for (int i = 0; i <= int'(limit_set[p]); i++)
                  send_byte(f[i]);
               frame_bytes += int'(limit_set[p]) + 1;
            end
         end
      end
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   // Result ready: random stalls, plus one long hold-off on request, counted here.
   initial begin : rsp_ready_drive
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !(rsp_idle_en && $urandom_range(99) < 20);
         end
      end
   end

   // Every result transaction is matched, field by field, against the oldest
   // expectation. Signals are read just after the edge, before any update lands.
   always @(posedge clock) begin : result_check
      stx_frm_pkg::result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            note_mismatch("result with nothing expected", 32'h0,
                          {5'h0, rsp_bus.kind, rsp_bus.data_byte, rsp_bus.frame_len,
                           rsp_bus.frame_end});
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            kind_seen[want.kind]++;
            if (rsp_bus.kind !== want.kind)
               note_mismatch("kind", want.kind, rsp_bus.kind);
            if (rsp_bus.data_byte !== want.data_byte)
               note_mismatch("data_byte", want.data_byte, rsp_bus.data_byte);
            if (rsp_bus.frame_len !== want.frame_len)
               note_mismatch("frame_len", want.frame_len, rsp_bus.frame_len);
            if (rsp_bus.frame_end !== want.frame_end)
               note_mismatch("frame_end", want.frame_end, rsp_bus.frame_end);
         end
      end
   end

   // Guard against a hang: a stuck handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= 8'h00;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      frame_limit = stx_frm_pkg::MAX_FRAME_LEN_RESET;
      len_decl    = '0;
      frame_hunt();

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_framing_basics();
      test_limit_edges();
      test_backpressure();
      test_random_traffic();
      wait_drain();

      $display("Sent %0d bytes opening %0d frames under %0d random length limits.",
               bytes_sent, frames_opened, limit_count);
      $display("Checked %0d results: %0d payload, %0d ok, %0d bad, %0d too long.",
               results_checked, kind_seen[stx_frm_pkg::KIND_PAYLOAD],
               kind_seen[stx_frm_pkg::KIND_OK], kind_seen[stx_frm_pkg::KIND_BAD],
               kind_seen[stx_frm_pkg::KIND_TOO_LONG]);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

[stx_length_lrc_frame_receiver.f]
hdl/stx_frm_pkg.sv
hdl/stx_frm_if.sv
hdl/stx_frm_front.sv
hdl/stx_frm_fifo.sv
hdl/stx_frm_back.sv
hdl/stx_length_lrc_frame_receiver.sv
tb/tb_top.sv
